// ----- src/btree_internal_node_engine_unit_assert.svh -----
// Assertion macros used by the checker file of the node engine.
`ifndef BTREE_INTERNAL_NODE_ENGINE_UNIT_ASSERT_SVH
`define BTREE_INTERNAL_NODE_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BNE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed in node engine checker.");

// Next-cycle implication, checked outside reset.
`define BNE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed in node engine checker.");

`endif

// ----- src/bne_pkg.sv -----
// ----------------------------------------------------------------------------
// bne_pkg
// Types and constants shared by the B+ tree internal node engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bne_pkg;

    localparam int MAX_KEYS = 16;
    localparam int IDX_W    = $clog2(MAX_KEYS);
    localparam int CNT_W    = 5;
    localparam int MODE_W   = 3;
    localparam int KEY_W    = 32;
    localparam int CHILD_W  = 31;
    localparam int STAT_W   = 2;
    localparam int IN_W     = 72;
    localparam int OUT_W    = 48;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR     = 3'd0,
        MODE_SET_RIGHT = 3'd1,
        MODE_INSERT    = 3'd2,
        MODE_ROUTE     = 3'd3,
        MODE_FIND      = 3'd4
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_SLOT,
        RES_RIGHT,
        RES_INS,
        RES_FULL,
        RES_RANGE,
        RES_MISS
    } t_res;

    typedef struct packed {
        logic load;
        logic clear;
        logic set_right;
        logic ptr_load_n;
        logic ptr_zero;
        logic ptr_inc;
        logic shift_wr;
        logic ins_fin;
        logic res_load;
        t_res res_sel;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        t_mode mode;
        logic  full;
        logic  idx_bad;
        logic  shift_end;
        logic  scan_end;
        logic  hit;
        logic  right_hit;
        logic  out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- src/bne_datapath.sv -----
// ----------------------------------------------------------------------------
// bne_datapath
// Key and child stores, slot pointer, comparators and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bne_datapath (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [bne_pkg::IN_W-1:0]   i_s_tdata,
    input  wire bne_pkg::t_dp_cmd           i_cmd,
    output bne_pkg::t_dp_stat               o_stat,
    output logic                            o_m_tvalid,
    input  wire logic                       i_m_tready,
    output logic [bne_pkg::OUT_W-1:0]       o_m_tdata
);

    logic [bne_pkg::KEY_W-1:0]   r_keys [bne_pkg::MAX_KEYS];
    logic [bne_pkg::CHILD_W-1:0] r_kids [bne_pkg::MAX_KEYS];

    bne_pkg::t_mode              r_mode;
    logic [bne_pkg::CNT_W-1:0]   r_idx;
    logic [bne_pkg::KEY_W-1:0]   r_key;
    logic [bne_pkg::CHILD_W-1:0] r_child;
    logic [bne_pkg::CNT_W-1:0]   r_ptr;
    logic [bne_pkg::CNT_W-1:0]   r_count;
    logic [bne_pkg::CHILD_W-1:0] r_right;
    bne_pkg::t_status            r_res_status;
    logic [bne_pkg::CNT_W-1:0]   r_res_slot;
    logic [bne_pkg::CHILD_W-1:0] r_res_child;
    logic                        r_o_valid;
    logic [bne_pkg::OUT_W-1:0]   r_o_data;

    logic [bne_pkg::CNT_W-1:0]   w_ptr_m1;
    logic [bne_pkg::CNT_W-1:0]   w_rd_ptr;
    logic [bne_pkg::IDX_W-1:0]   w_rd_addr;
    logic [bne_pkg::KEY_W-1:0]   w_rd_key;
    logic [bne_pkg::CHILD_W-1:0] w_rd_kid;
    logic                        w_is_route;
    logic                        w_hit;

    assign w_ptr_m1   = r_ptr - bne_pkg::CNT_W'(1);
    assign w_rd_ptr   = (r_mode == bne_pkg::MODE_INSERT) ? w_ptr_m1 : r_ptr;
    assign w_rd_addr  = w_rd_ptr[bne_pkg::IDX_W-1:0];
    assign w_rd_key   = r_keys[w_rd_addr];
    assign w_rd_kid   = r_kids[w_rd_addr];
    assign w_is_route = (r_mode == bne_pkg::MODE_ROUTE);

    always_comb begin
        if (w_is_route) begin
            w_hit = ($signed(r_key) < $signed(w_rd_key));
        end else begin
            w_hit = (w_rd_kid == r_child);
        end
    end

    assign o_stat.mode      = r_mode;
    assign o_stat.full      = (r_count >= bne_pkg::CNT_W'(bne_pkg::MAX_KEYS));
    assign o_stat.idx_bad   = (r_idx > r_count);
    assign o_stat.shift_end = (r_ptr == r_idx);
    assign o_stat.scan_end  = (r_ptr == r_count);
    assign o_stat.hit       = w_hit;
    assign o_stat.right_hit = (r_right == r_child);
    assign o_stat.out_free  = !r_o_valid || i_m_tready;

    // The stores hold no reset; entries at or above the count are never read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_wr) begin
            r_keys[r_ptr[bne_pkg::IDX_W-1:0]] <= w_rd_key;
            r_kids[r_ptr[bne_pkg::IDX_W-1:0]] <= (w_ptr_m1 == r_idx) ? r_child : w_rd_kid;
        end else if (i_cmd.ins_fin) begin
            r_keys[r_idx[bne_pkg::IDX_W-1:0]] <= r_key;
            if (r_idx == r_count) begin
                r_kids[r_count[bne_pkg::IDX_W-1:0]] <= r_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= bne_pkg::t_mode'(i_s_tdata[2:0]);
            r_idx   <= i_s_tdata[7:3];
            r_key   <= i_s_tdata[39:8];
            r_child <= i_s_tdata[70:40];
        end
        if (i_cmd.ptr_load_n) begin
            r_ptr <= r_count;
        end else if (i_cmd.ptr_zero) begin
            r_ptr <= '0;
        end else if (i_cmd.ptr_inc) begin
            r_ptr <= r_ptr + bne_pkg::CNT_W'(1);
        end else if (i_cmd.shift_wr) begin
            r_ptr <= w_ptr_m1;
        end
        if (i_cmd.res_load) begin
            case (i_cmd.res_sel)
                bne_pkg::RES_SLOT: begin
                    r_res_status <= bne_pkg::ST_OK;
                    r_res_slot   <= r_ptr;
                    r_res_child  <= w_is_route ? w_rd_kid : '0;
                end
                bne_pkg::RES_RIGHT: begin
                    r_res_status <= bne_pkg::ST_OK;
                    r_res_slot   <= r_count;
                    r_res_child  <= w_is_route ? r_right : '0;
                end
                bne_pkg::RES_INS: begin
                    r_res_status <= bne_pkg::ST_OK;
                    r_res_slot   <= r_idx;
                    r_res_child  <= '0;
                end
                bne_pkg::RES_FULL: begin
                    r_res_status <= bne_pkg::ST_FULL;
                    r_res_slot   <= '0;
                    r_res_child  <= '0;
                end
                bne_pkg::RES_RANGE: begin
                    r_res_status <= bne_pkg::ST_RANGE;
                    r_res_slot   <= '0;
                    r_res_child  <= '0;
                end
                bne_pkg::RES_MISS: begin
                    r_res_status <= bne_pkg::ST_NOTFOUND;
                    r_res_slot   <= '0;
                    r_res_child  <= '0;
                end
                default: begin
                    r_res_status <= bne_pkg::ST_OK;
                    r_res_slot   <= '0;
                    r_res_child  <= '0;
                end
            endcase
        end
        if (i_cmd.emit) begin
            r_o_data <= {5'd0, r_count, r_res_child, r_res_slot, r_res_status};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_right   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
                r_right <= '0;
            end else if (i_cmd.set_right) begin
                r_right <= r_child;
            end else if (i_cmd.ins_fin) begin
                r_count <= r_count + bne_pkg::CNT_W'(1);
                if (r_idx == r_count) begin
                    r_right <= r_child;
                end
            end
            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;

endmodule

`default_nettype wire

// ----- src/bne_controller.sv -----
// ----------------------------------------------------------------------------
// bne_controller
// Sequences one request at a time: decode, slot shift or scan, result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bne_controller (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire bne_pkg::t_dp_stat  i_stat,
    output bne_pkg::t_dp_cmd        o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd      = '0;
        o_cmd.res_sel = bne_pkg::RES_ZERO;
        n_state    = r_state;
        o_s_tready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_stat.mode)
                    bne_pkg::MODE_CLEAR: begin
                        o_cmd.clear    = 1'b1;
                        o_cmd.res_load = 1'b1;
                        n_state        = S_DONE;
                    end
                    bne_pkg::MODE_SET_RIGHT: begin
                        o_cmd.set_right = 1'b1;
                        o_cmd.res_load  = 1'b1;
                        n_state         = S_DONE;
                    end
                    bne_pkg::MODE_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_sel  = bne_pkg::RES_FULL;
                            n_state        = S_DONE;
                        end else if (i_stat.idx_bad) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_sel  = bne_pkg::RES_RANGE;
                            n_state        = S_DONE;
                        end else begin
                            o_cmd.ptr_load_n = 1'b1;
                            n_state          = S_SHIFT;
                        end
                    end
                    bne_pkg::MODE_ROUTE, bne_pkg::MODE_FIND: begin
                        o_cmd.ptr_zero = 1'b1;
                        n_state        = S_SCAN;
                    end
                    default: begin
                        o_cmd.res_load = 1'b1;
                        n_state        = S_DONE;
                    end
                endcase
            end
            S_SHIFT: begin
                if (i_stat.shift_end) begin
                    o_cmd.ins_fin  = 1'b1;
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = bne_pkg::RES_INS;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.shift_wr = 1'b1;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_end) begin
                    o_cmd.res_load = 1'b1;
                    if (i_stat.mode == bne_pkg::MODE_ROUTE || i_stat.right_hit) begin
                        o_cmd.res_sel = bne_pkg::RES_RIGHT;
                    end else begin
                        o_cmd.res_sel = bne_pkg::RES_MISS;
                    end
                    n_state = S_DONE;
                end else if (i_stat.hit) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = bne_pkg::RES_SLOT;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- src/btree_internal_node_engine_unit.sv -----
// Sequence: an accepted item is registered and then decoded; clear, set, unused modes
// and a full or out-of-range insert load their result at once, an insert otherwise
// shifts slots down from the count to slot_index, and route or find scan upward from
// slot zero until a hit or the count. Flow: the next item is taken only after the
// result is loaded into the output register; a result left waiting holds off that load.
// Reset (synchronous, active low) empties the node and clears the right child and output valid.
// ----------------------------------------------------------------------------
// btree_internal_node_engine_unit
// One B+ tree internal node with clear, set-right, insert, route and child lookup requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btree_internal_node_engine_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // mode[2:0], slot_index[7:3], search_key[39:8], child_id[70:40], zero pad.
    input  wire logic [bne_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // status[1:0], found_slot[6:2], found_child[37:7], key_total[42:38], zero pad.
    output logic [bne_pkg::OUT_W-1:0]       m_axis_tdata
);

    bne_pkg::t_dp_cmd  w_cmd;
    bne_pkg::t_dp_stat w_stat;

    bne_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    bne_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_axis_tdata),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ----- src/bne_checker.sv -----
// ----------------------------------------------------------------------------
// bne_checker
// Port-level checks on the result stream of the node engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "btree_internal_node_engine_unit_assert.svh"

module bne_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       m_axis_tvalid,
    input wire logic                       m_axis_tready,
    input wire logic [bne_pkg::OUT_W-1:0]  m_axis_tdata
);

    `BNE_ASSERT_NXT(a_hold_stalled, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `BNE_ASSERT_IMP(a_total_bound, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[42:38] <= 5'(bne_pkg::MAX_KEYS))
    `BNE_ASSERT_IMP(a_slot_bound, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[1:0] == bne_pkg::ST_OK, m_axis_tdata[6:2] <= m_axis_tdata[42:38])
    `BNE_ASSERT_IMP(a_error_clean, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[1:0] != bne_pkg::ST_OK, m_axis_tdata[6:2] == 5'd0 && m_axis_tdata[37:7] == 31'd0)

endmodule

bind btree_internal_node_engine_unit bne_checker u_bne_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
